// ----- sv/cpts_pkg.sv -----
// ----------------------------------------------------------------------------
// cpts_pkg
// Shared types and constants of the counter priority task scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package cpts_pkg;

  localparam int MAX_TASKS_DEF = 16;
  localparam int PID_BITS_DEF  = 16;

  localparam int TPID_W  = 16;
  localparam int PRIO_W  = 8;
  localparam int CNT_W   = 9;
  localparam int PCNT_W  = 8;
  localparam int OSLOT_W = 4;
  localparam int OPID_W  = 16;

  typedef enum logic [2:0] {
    CMD_TICK    = 3'd0,
    CMD_YIELD   = 3'd1,
    CMD_EXIT    = 3'd2,
    CMD_KILL    = 3'd3,
    CMD_CREATE  = 3'd4,
    CMD_PRE_OFF = 3'd5,
    CMD_PRE_ON  = 3'd6,
    CMD_NOP     = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_NO_PID  = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_REFUSED = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_PICK,
    S_REFILL,
    S_KILL,
    S_FREE,
    S_DONE
  } state_t;

  typedef struct packed {
    cmd_t                command;
    logic [TPID_W-1:0]   target_pid;
    logic [PRIO_W-1:0]   new_priority;
  } in_word_t;

  typedef struct packed {
    logic [OSLOT_W-1:0]  current_slot;
    logic [OPID_W-1:0]   current_pid;
    logic                switched;
    status_t             status;
  } out_word_t;

endpackage

`default_nettype wire

// ----- sv/cpts_ram.sv -----
// ----------------------------------------------------------------------------
// cpts_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module cpts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- sv/cpts_oreg.sv -----
// ----------------------------------------------------------------------------
// cpts_oreg
// Result output register: holds one word until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module cpts_oreg (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                load_valid,
  input  cpts_pkg::out_word_t      load_data,
  output logic                     load_ready,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output cpts_pkg::out_word_t      out_data
);

  import cpts_pkg::*;

  logic      full_r;
  logic      full_nxt;
  out_word_t data_r;

  assign load_ready = !full_r || !out_stall;
  assign out_valid  = full_r;
  assign out_data   = data_r;

  always_comb begin
    full_nxt = full_r;
    if (full_r && !out_stall) begin
      full_nxt = 1'b0;
    end
    if (load_valid && load_ready) begin
      full_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
    end else begin
      full_r <= full_nxt;
    end
    if (load_valid && load_ready) begin
      data_r <= load_data;
    end
  end

endmodule

`default_nettype wire

// ----- sv/counter_priority_task_scheduler_core.sv -----
// ----------------------------------------------------------------------------
// counter_priority_task_scheduler_core
// Counter-based priority task scheduler with its task table in one RAM.
// ----------------------------------------------------------------------------
// One command word is taken at a time and gives one result word. Preempt on,
// preempt off and a tick that does not reschedule pass through the
// read-modify-write state S_MOD before S_DONE; no-op and refused exit go
// straight to S_DONE. Kill scans the table one slot per cycle, create scans
// the valid bits one slot per cycle. A reschedule is one pass over the table
// RAM and, when every counter is zero, a second refill pass. The longest item
// is a kill of the running task found in the last slot followed by a
// reschedule and a refill pass; the single read port of the task RAM sets
// the length of each pass. A stalled output with a full output register
// holds the block in its final cycle until the register frees up.
// The next command word is accepted while a finished result waits in the
// output register.
`default_nettype none

module counter_priority_task_scheduler_core #(
  parameter int MAX_TASKS = cpts_pkg::MAX_TASKS_DEF,
  parameter int PID_BITS  = cpts_pkg::PID_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  cpts_pkg::in_word_t       in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output cpts_pkg::out_word_t      out_data,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [cpts_pkg::PRIO_W-1:0] cfg_data
);

  import cpts_pkg::*;

  localparam int SW     = $clog2(MAX_TASKS);
  localparam int PC_LO  = 0;
  localparam int CNT_LO = PC_LO + PCNT_W;
  localparam int PRI_LO = CNT_LO + CNT_W;
  localparam int PID_LO = PRI_LO + PRIO_W;
  localparam int EW     = PID_LO + PID_BITS;
  localparam logic [SW-1:0] LAST  = SW'(MAX_TASKS - 1);
  localparam logic [SW:0]   NSLOT = (SW+1)'(MAX_TASKS);

  state_t                state_r, state_nxt;
  cmd_t                  cmd_r, cmd_nxt;
  logic [PID_BITS-1:0]   tgt_r, tgt_nxt;
  logic [PRIO_W-1:0]     prio_r, prio_nxt;
  logic [PRIO_W-1:0]     idle_prio_r, idle_prio_nxt;
  logic [SW-1:0]         run_r, run_nxt;
  logic [PID_BITS-1:0]   cur_pid_r, cur_pid_nxt;
  logic [PID_BITS-1:0]   next_pid_r, next_pid_nxt;
  logic [MAX_TASKS-1:0]  valid_r, valid_nxt;
  logic                  slot0_wr_r, slot0_wr_nxt;
  logic [SW:0]           iss_r, iss_nxt;
  logic                  pend_r, pend_nxt;
  logic [SW-1:0]         addr_d_r, addr_d_nxt;
  logic [SW-1:0]         best_r, best_nxt;
  logic [CNT_W-1:0]      bestc_r, bestc_nxt;
  logic [PID_BITS-1:0]   bestpid_r, bestpid_nxt;
  logic                  switched_r, switched_nxt;
  status_t               status_r, status_nxt;

  logic                  ram_we;
  logic [SW-1:0]         ram_waddr;
  logic [EW-1:0]         ram_wdata;
  logic [SW-1:0]         ram_raddr;
  logic [EW-1:0]         ram_rdata;

  logic                  rd_zero;
  logic [PID_BITS-1:0]   e_pid;
  logic [PRIO_W-1:0]     e_prio;
  logic [CNT_W-1:0]      e_cnt;
  logic [PCNT_W-1:0]     e_pc;
  logic [CNT_W-1:0]      refill_c;
  logic [CNT_W-1:0]      cand_c;
  logic [CNT_W-1:0]      mod_c;
  logic [PCNT_W-1:0]     mod_pc;
  logic                  mod_resched;

  logic                  accept;
  logic                  last;
  logic                  kill_hit;
  logic [SW-1:0]         free_idx;
  logic                  free_hit;
  logic                  free_end;
  logic                  scan_st;
  logic [PID_BITS-1:0]   np_inc;

  out_word_t             load_data;
  logic                  load_valid;
  logic                  load_ready;
  logic [31:0]           slot_ext;
  logic [31:0]           pid_ext;

  cpts_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_TASKS)
  ) u_task_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  cpts_oreg u_oreg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (load_valid),
    .load_data  (load_data),
    .load_ready (load_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign accept    = in_valid && (state_r == S_IDLE);

  // slot 0 reads as zero, but for its priority, until its entry is first written
  assign rd_zero  = (addr_d_r == '0) && !slot0_wr_r;
  assign e_pid    = rd_zero ? '0 : ram_rdata[PID_LO +: PID_BITS];
  assign e_prio   = (addr_d_r == '0) ? idle_prio_r : ram_rdata[PRI_LO +: PRIO_W];
  assign e_cnt    = rd_zero ? '0 : ram_rdata[CNT_LO +: CNT_W];
  assign e_pc     = rd_zero ? '0 : ram_rdata[PC_LO +: PCNT_W];
  assign refill_c = {1'b0, e_cnt[CNT_W-1:1]} + CNT_W'(e_prio);
  assign cand_c   = (state_r == S_REFILL) ? refill_c : e_cnt;

  assign last     = pend_r && (addr_d_r == LAST);
  assign kill_hit = pend_r && valid_r[addr_d_r] && (e_pid == tgt_r);
  assign free_idx = iss_r[SW-1:0];
  assign free_hit = !valid_r[free_idx];
  assign free_end = (free_idx == LAST);
  assign scan_st  = (state_r == S_PICK) || (state_r == S_REFILL) || (state_r == S_KILL);
  assign np_inc   = next_pid_r + PID_BITS'(1);

  always_comb begin
    mod_c       = e_cnt;
    mod_pc      = e_pc;
    mod_resched = 1'b0;
    case (cmd_r)
      CMD_TICK: begin
        mod_c       = (e_cnt == '0) ? '0 : e_cnt - CNT_W'(1);
        mod_resched = (mod_c == '0) && (e_pc == '0);
      end
      CMD_YIELD: begin
        mod_c       = '0;
        mod_resched = 1'b1;
      end
      CMD_PRE_OFF: begin
        mod_pc = (e_pc == '1) ? e_pc : e_pc + PCNT_W'(1);
      end
      CMD_PRE_ON: begin
        mod_pc = (e_pc == '0) ? e_pc : e_pc - PCNT_W'(1);
      end
      default: begin
        mod_pc = e_pc;
      end
    endcase
  end

  // best-slot tracking over a table pass
  always_comb begin
    best_nxt    = best_r;
    bestc_nxt   = bestc_r;
    bestpid_nxt = bestpid_r;
    if (pend_r && ((state_r == S_PICK) || (state_r == S_REFILL))) begin
      if (addr_d_r == '0) begin
        best_nxt    = '0;
        bestc_nxt   = cand_c;
        bestpid_nxt = e_pid;
      end else if (valid_r[addr_d_r] && (cand_c > bestc_r)) begin
        best_nxt    = addr_d_r;
        bestc_nxt   = cand_c;
        bestpid_nxt = e_pid;
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_data.command)
            CMD_TICK, CMD_YIELD, CMD_PRE_OFF, CMD_PRE_ON: state_nxt = S_MOD;
            CMD_EXIT:   state_nxt = (run_r == '0) ? S_DONE : S_PICK;
            CMD_KILL:   state_nxt = S_KILL;
            CMD_CREATE: state_nxt = S_FREE;
            default:    state_nxt = S_DONE;
          endcase
        end
      end
      S_MOD: begin
        state_nxt = mod_resched ? S_PICK : S_DONE;
      end
      S_PICK: begin
        if (last) begin
          state_nxt = (bestc_nxt == '0) ? S_REFILL : S_DONE;
        end
      end
      S_REFILL: begin
        if (last) begin
          state_nxt = S_DONE;
        end
      end
      S_KILL: begin
        if (kill_hit) begin
          state_nxt = ((addr_d_r != '0) && (addr_d_r == run_r)) ? S_PICK : S_DONE;
        end else if (last) begin
          state_nxt = S_DONE;
        end
      end
      S_FREE: begin
        if (free_hit || free_end) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (load_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // datapath, table and result controls
  always_comb begin
    cmd_nxt       = cmd_r;
    tgt_nxt       = tgt_r;
    prio_nxt      = prio_r;
    idle_prio_nxt = idle_prio_r;
    run_nxt       = run_r;
    cur_pid_nxt   = cur_pid_r;
    next_pid_nxt  = next_pid_r;
    valid_nxt     = valid_r;
    slot0_wr_nxt  = slot0_wr_r;
    iss_nxt       = iss_r;
    pend_nxt      = 1'b0;
    addr_d_nxt    = addr_d_r;
    switched_nxt  = switched_r;
    status_nxt    = status_r;
    ram_we        = 1'b0;
    ram_waddr     = addr_d_r;
    ram_wdata     = {e_pid, e_prio, e_cnt, e_pc};
    ram_raddr     = (state_r == S_IDLE) ? run_r : iss_r[SW-1:0];
    load_valid    = 1'b0;

    if (cfg_valid && cfg_ready) begin
      idle_prio_nxt = cfg_data;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt      = in_data.command;
          tgt_nxt      = PID_BITS'(in_data.target_pid);
          prio_nxt     = in_data.new_priority;
          status_nxt   = STAT_OK;
          switched_nxt = 1'b0;
          addr_d_nxt   = run_r;
          iss_nxt      = (SW+1)'(1);
          if (in_data.command == CMD_EXIT) begin
            if (run_r == '0) begin
              status_nxt = STAT_REFUSED;
            end else begin
              valid_nxt[run_r] = 1'b0;
            end
          end
        end
      end
      S_MOD: begin
        ram_we    = 1'b1;
        ram_wdata = {e_pid, e_prio, mod_c, mod_pc};
      end
      S_REFILL: begin
        if (pend_r && valid_r[addr_d_r]) begin
          ram_we    = 1'b1;
          ram_wdata = {e_pid, e_prio, refill_c, e_pc};
        end
      end
      S_KILL: begin
        if (kill_hit) begin
          if (addr_d_r == '0) begin
            status_nxt = STAT_REFUSED;
          end else begin
            valid_nxt[addr_d_r] = 1'b0;
          end
        end else if (last) begin
          status_nxt = STAT_NO_PID;
        end
      end
      S_FREE: begin
        ram_waddr = free_idx;
        ram_wdata = {next_pid_r, prio_r, CNT_W'(prio_r), PCNT_W'(0)};
        if (free_hit) begin
          ram_we              = 1'b1;
          valid_nxt[free_idx] = 1'b1;
          next_pid_nxt        = (np_inc == '0) ? PID_BITS'(1) : np_inc;
        end else if (free_end) begin
          status_nxt = STAT_FULL;
        end else begin
          iss_nxt = iss_r + (SW+1)'(1);
        end
      end
      S_DONE: begin
        load_valid = 1'b1;
      end
      default: begin
        load_valid = 1'b0;
      end
    endcase

    if (ram_we && (ram_waddr == '0)) begin
      slot0_wr_nxt = 1'b1;
    end

    // table pass read pipeline
    if ((state_nxt != state_r) &&
        ((state_nxt == S_PICK) || (state_nxt == S_REFILL) || (state_nxt == S_KILL))) begin
      iss_nxt  = '0;
      pend_nxt = 1'b0;
    end else if (scan_st && (state_nxt == state_r) && (iss_r != NSLOT)) begin
      iss_nxt    = iss_r + (SW+1)'(1);
      pend_nxt   = 1'b1;
      addr_d_nxt = iss_r[SW-1:0];
    end

    if (((state_r == S_PICK) || (state_r == S_REFILL)) && (state_nxt == S_DONE)) begin
      switched_nxt = (best_nxt != run_r);
      run_nxt      = best_nxt;
      cur_pid_nxt  = bestpid_nxt;
    end
  end

  assign slot_ext               = 32'(run_r);
  assign pid_ext                = 32'(cur_pid_r);
  assign load_data.current_slot = slot_ext[OSLOT_W-1:0];
  assign load_data.current_pid  = pid_ext[OPID_W-1:0];
  assign load_data.switched     = switched_r;
  assign load_data.status       = status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idle_prio_r <= PRIO_W'(1);
      run_r       <= '0;
      cur_pid_r   <= '0;
      next_pid_r  <= PID_BITS'(1);
      valid_r     <= MAX_TASKS'(1);
      slot0_wr_r  <= 1'b0;
      pend_r      <= 1'b0;
      switched_r  <= 1'b0;
      status_r    <= STAT_OK;
    end else begin
      state_r     <= state_nxt;
      idle_prio_r <= idle_prio_nxt;
      run_r       <= run_nxt;
      cur_pid_r   <= cur_pid_nxt;
      next_pid_r  <= next_pid_nxt;
      valid_r     <= valid_nxt;
      slot0_wr_r  <= slot0_wr_nxt;
      pend_r      <= pend_nxt;
      switched_r  <= switched_nxt;
      status_r    <= status_nxt;
    end
    cmd_r     <= cmd_nxt;
    tgt_r     <= tgt_nxt;
    prio_r    <= prio_nxt;
    iss_r     <= iss_nxt;
    addr_d_r  <= addr_d_nxt;
    best_r    <= best_nxt;
    bestc_r   <= bestc_nxt;
    bestpid_r <= bestpid_nxt;
  end

  a_idle_slot_valid: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r[0])
    else $error("idle slot lost its valid bit");

  a_running_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> valid_r[run_r])
    else $error("running slot is not a valid task");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r != S_IDLE))
    else $error("accepted word did not start work");

  a_error_no_switch: assert property (@(posedge clk) disable iff (!rst_n)
    (status_r != STAT_OK) |-> !switched_r)
    else $error("error status together with a task switch");

endmodule

`default_nettype wire

// ----- verif/tb_counter_priority_task_scheduler_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_counter_priority_task_scheduler_core
// Self-checking testbench for the counter priority task scheduler core.
// ----------------------------------------------------------------------------
// Command words go in through the stall handshake; every result word is
// compared field by field against a task table model kept in the bench and
// stepped once per accepted command. Tests cover every command and refusal,
// a full table, preempt count saturation and random command mixes under
// several idle priorities, with random input gaps and output stalls.
// ----------------------------------------------------------------------------

module tb_counter_priority_task_scheduler_core;
  import cpts_pkg::*;

  localparam int     NSLOT         = MAX_TASKS_DEF;
  localparam int     SETTLE_CYCLES = 2 * NSLOT + 16;
  localparam longint CYCLE_LIMIT   = 64'd12_000_000;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  in_word_t            in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_word_t           out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [PRIO_W-1:0]   cfg_data  = '0;

  bit                  idle_en   = 1'b1;
  longint              cycle_count = 0;
  int                  errors = 0;
  int                  sent_words = 0;
  int                  checked_words = 0;
  int                  cfg_writes = 0;
  int                  switch_count = 0;
  int                  odd_status_count = 0;
  int                  pid_wraps = 0;

  out_word_t           pending_results[$];

  // task table model
  logic                task_live  [NSLOT];
  logic [TPID_W-1:0]   task_pid   [NSLOT];
  logic [PRIO_W-1:0]   task_prio  [NSLOT];
  logic [CNT_W-1:0]    task_slice [NSLOT];
  logic [PCNT_W-1:0]   task_lock  [NSLOT];
  int                  run_slot;
  logic [TPID_W-1:0]   pid_next;
  logic [PRIO_W-1:0]   idle_prio;

  counter_priority_task_scheduler_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb_counter_priority_task_scheduler_core NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= idle_en && ($urandom_range(99) < 23);
  end

  // ---------------------------------------------------------------- model
  function automatic void drop_task(int s);
    task_live[s]  = 1'b0;
    task_pid[s]   = '0;
    task_prio[s]  = '0;
    task_slice[s] = '0;
    task_lock[s]  = '0;
  endfunction

  function automatic void clear_model();
    for (int i = 0; i < NSLOT; i++) drop_task(i);
    idle_prio    = 8'd1;
    task_live[0] = 1'b1;
    task_prio[0] = idle_prio;
    run_slot     = 0;
    pid_next     = 1;
  endfunction

  function automatic int richest_slot();
    int best;
    best = 0;
    for (int i = 1; i < NSLOT; i++)
      if (task_live[i] && task_slice[i] > task_slice[best]) best = i;
    return best;
  endfunction

  function automatic void pick_runner();
    int best;
    best = richest_slot();
    if (task_slice[best] == '0) begin
      for (int i = 0; i < NSLOT; i++)
        if (task_live[i]) task_slice[i] = (task_slice[i] >> 1) + CNT_W'(task_prio[i]);
      best = richest_slot();
    end
    run_slot = best;
  endfunction

  function automatic out_word_t predict_schedule(in_word_t w);
    int        prev;
    int        r;
    int        hit;
    status_t   st;
    out_word_t res;
    prev = run_slot;
    r    = run_slot;
    st   = STAT_OK;
    hit  = NSLOT;
    case (w.command)
      CMD_TICK: begin
        if (task_slice[r] != '0) task_slice[r] = task_slice[r] - 1'b1;
        if (task_slice[r] == '0 && task_lock[r] == '0) pick_runner();
      end
      CMD_YIELD: begin
        task_slice[r] = '0;
        pick_runner();
      end
      CMD_EXIT: begin
        if (r == 0) begin
          st = STAT_REFUSED;
        end else begin
          drop_task(r);
          pick_runner();
        end
      end
      CMD_KILL: begin
        for (int i = NSLOT - 1; i >= 0; i--)
          if (task_live[i] && task_pid[i] == w.target_pid) hit = i;
        if (hit == NSLOT) begin
          st = STAT_NO_PID;
        end else if (hit == 0) begin
          st = STAT_REFUSED;
        end else begin
          drop_task(hit);
          if (hit == r) pick_runner();
        end
      end
      CMD_CREATE: begin
        for (int i = NSLOT - 1; i >= 1; i--)
          if (!task_live[i]) hit = i;
        if (hit == NSLOT) begin
          st = STAT_FULL;
        end else begin
          task_live[hit]  = 1'b1;
          task_pid[hit]   = pid_next;
          task_prio[hit]  = w.new_priority;
          task_slice[hit] = CNT_W'(w.new_priority);
          task_lock[hit]  = '0;
          pid_next = pid_next + 1'b1;
          if (pid_next == '0) begin
            pid_next = 1;
            pid_wraps++;
          end
        end
      end
      CMD_PRE_OFF: begin
        if (task_lock[r] != '1) task_lock[r] = task_lock[r] + 1'b1;
      end
      CMD_PRE_ON: begin
        if (task_lock[r] != '0) task_lock[r] = task_lock[r] - 1'b1;
      end
      default: ;
    endcase
    res.current_slot = OSLOT_W'(run_slot);
    res.current_pid  = task_pid[run_slot];
    res.switched     = (run_slot != prev);
    res.status       = st;
    return res;
  endfunction

  function automatic int free_slots();
    int n;
    n = 0;
    for (int i = 1; i < NSLOT; i++)
      if (!task_live[i]) n++;
    return n;
  endfunction

  function automatic logic [TPID_W-1:0] some_live_pid(logic [TPID_W-1:0] dflt);
    int pick[$];
    for (int i = 1; i < NSLOT; i++)
      if (task_live[i]) pick.push_back(i);
    if (pick.size() == 0) return dflt;
    return task_pid[pick[$urandom_range(pick.size() - 1)]];
  endfunction

  // ---------------------------------------------------------------- checking
  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    if (errors <= 40)
      $display("MISMATCH %s: got %0d, expected %0d (result %0d)", what, got, want,
               checked_words);
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result word", out_data, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_data.current_slot !== want.current_slot)
          report_mismatch("current_slot", out_data.current_slot, want.current_slot);
        if (out_data.current_pid !== want.current_pid)
          report_mismatch("current_pid", out_data.current_pid, want.current_pid);
        if (out_data.switched !== want.switched)
          report_mismatch("switched", out_data.switched, want.switched);
        if (out_data.status !== want.status)
          report_mismatch("status", out_data.status, want.status);
        checked_words++;
      end
    end
  end

  // ---------------------------------------------------------------- driving
  task automatic issue(cmd_t c, logic [TPID_W-1:0] pid, logic [PRIO_W-1:0] prio);
    in_word_t  w;
    out_word_t res;
    int        gap;
    w.command      = c;
    w.target_pid   = pid;
    w.new_priority = prio;
    gap = 0;
    if (idle_en && $urandom_range(99) < 23) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    res = predict_schedule(w);
    pending_results.push_back(res);
    sent_words++;
    if (res.switched) switch_count++;
    if (res.status != STAT_OK) odd_status_count++;
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_idle_prio(logic [PRIO_W-1:0] v);
    wait_results();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    idle_prio    = v;
    task_prio[0] = v;
    cfg_writes++;
  endtask

  // ---------------------------------------------------------------- tests
  task automatic test_basic_commands();
    issue(CMD_NOP,     16'hFFFF, 8'hFF);
    issue(CMD_TICK,    16'h0000, 8'h00);  // idle refill from reset
    issue(CMD_EXIT,    16'h0000, 8'h00);  // idle cannot exit
    issue(CMD_KILL,    16'h0000, 8'h00);  // idle cannot be killed
    issue(CMD_KILL,    16'hFFFF, 8'h00);  // unknown pid
    issue(CMD_CREATE,  16'hFFFF, 8'hFF);
    issue(CMD_CREATE,  16'h0000, 8'h00);  // zero priority task
    issue(CMD_CREATE,  16'h5A5A, 8'h01);
    issue(CMD_TICK,    16'hA5A5, 8'h00);
    issue(CMD_PRE_OFF, 16'h0000, 8'h00);
    issue(CMD_YIELD,   16'h0000, 8'h00);
    issue(CMD_TICK,    16'h0000, 8'h00);  // slice hits zero, all-zero refill
    issue(CMD_PRE_ON,  16'h0000, 8'h00);
    issue(CMD_PRE_ON,  16'h0000, 8'h00);  // lock already zero
    issue(CMD_KILL,    16'h0003, 8'h00);  // not the running task
    issue(CMD_KILL,    16'h0001, 8'h00);
    issue(CMD_EXIT,    16'h0000, 8'h00);
    issue(CMD_CREATE,  16'h0000, 8'h80);
    issue(CMD_YIELD,   16'h0000, 8'h00);
    issue(CMD_EXIT,    16'h0000, 8'h00);
    issue(CMD_KILL,    16'h0002, 8'h00);
  endtask

  task automatic test_table_full();
    while (free_slots() != 0)
      issue(CMD_CREATE, TPID_W'($urandom),
            ($urandom_range(2) == 0) ? 8'h00 : PRIO_W'($urandom_range(1, 255)));
    issue(CMD_CREATE, 16'h0000, 8'h10);
    issue(CMD_YIELD,  16'h0000, 8'h00);
    issue(CMD_TICK,   16'h0000, 8'h00);
    issue(CMD_KILL,   task_pid[7], 8'h00);
    issue(CMD_CREATE, 16'h0000, 8'hFF);
    issue(CMD_CREATE, 16'h0000, 8'h01);
    issue(CMD_EXIT,   16'h0000, 8'h00);
    issue(CMD_KILL,   16'h0000, 8'h00);
  endtask

  task automatic test_preempt_limits();
    if (free_slots() != 0) issue(CMD_CREATE, 16'h0000, 8'hC8);
    issue(CMD_YIELD, 16'h0000, 8'h00);
    repeat (260) issue(CMD_PRE_OFF, TPID_W'($urandom), PRIO_W'($urandom));
    repeat (8) issue(CMD_TICK, 16'h0000, 8'h00);
    repeat (260) issue(CMD_PRE_ON, TPID_W'($urandom), PRIO_W'($urandom));
    repeat (8) issue(CMD_TICK, 16'h0000, 8'h00);
  endtask

  task automatic test_random_mix(int n_items);
    int                roll;
    logic [TPID_W-1:0] pid;
    logic [PRIO_W-1:0] prio;
    cmd_t              c;
    for (int k = 0; k < n_items; k++) begin
      roll = $urandom_range(99);
      pid  = TPID_W'($urandom);
      prio = ($urandom_range(1) == 0) ? PRIO_W'($urandom_range(0, 7)) : PRIO_W'($urandom);
      if (roll < 30) begin
        c = CMD_TICK;
      end else if (roll < 38) begin
        c = CMD_YIELD;
      end else if (roll < 45) begin
        c = CMD_EXIT;
      end else if (roll < 60) begin
        c = CMD_KILL;
        if ($urandom_range(99) < 80) pid = some_live_pid(pid);
      end else if (roll < 78) begin
        c = CMD_CREATE;
      end else if (roll < 85) begin
        c = CMD_PRE_OFF;
      end else if (roll < 93) begin
        c = CMD_PRE_ON;
      end else begin
        c = CMD_NOP;
      end
      issue(c, pid, prio);
    end
  endtask

  initial begin
    clear_model();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_basic_commands();
    write_idle_prio(8'hFF);
    test_table_full();
    write_idle_prio(8'h01);
    test_preempt_limits();
    write_idle_prio(8'h80);
    test_random_mix(280);
    write_idle_prio(PRIO_W'($urandom_range(1, 255)));
    idle_en = 1'b0;
    test_random_mix(280);
    idle_en = 1'b1;
    write_idle_prio(8'hFF);
    test_random_mix(280);
    write_idle_prio(8'h01);
    test_random_mix(280);
    wait_results();

    $display("covered %0d command words, %0d results checked, %0d idle priority writes",
             sent_words, checked_words, cfg_writes);
    $display("saw %0d task switches, %0d refused or missed commands, %0d pid wraps",
             switch_count, odd_status_count, pid_wraps);
    if (errors == 0) begin
      $display("tb_counter_priority_task_scheduler_core OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("tb_counter_priority_task_scheduler_core NOT OK");
    end
    $finish;
  end

endmodule
